FILE: design/stqs_pkg.sv
// shared types and constants for the streaming top-q selector
package stqs_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic CFG_KEEP   = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    localparam logic [6:0]  KEEP_RESET   = 7'd16;
    localparam logic [7:0]  WINDOW_RESET = 8'd32;
    localparam logic [31:0] VALUE_MIN    = 32'h8000_0000;
    localparam logic [31:0] THR_RESET    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] threshold;
        logic               last;
    } t_out;

    typedef struct packed {
        logic acc;
        logic sel_init;
        logic rd_lo;
        logic ld_pv;
        logic np_init;
        logic rd_im1;
        logic step;
        logic sw_hinp;
        logic sw_ra;
        logic sw_rb;
        logic sw_wa;
        logic sw_wb;
        logic part_end;
        logic em_rd;
        logic em_out;
        logic clr_wr;
    } t_cmd;

    typedef struct packed {
        logic ins_sel;
        logic i_gt_lo;
        logic x_gt_pv;
        logic p_eq_t;
        logic clr_last;
        logic em_last;
    } t_sts;

endpackage

FILE: design/streaming_top_q_selector_unit.sv
// top level of the streaming top-q selector
// insert and clear complete without leaving idle; an insert that fills slot 0 adds a selection pass
// selection: quickselect on a 1R1W store; a swap runs SWA to SWD, a scan step P3 and P4
// query: selection pass, then q results, each read from the store in ERD, sent in EOUT
// synchronous reset runs a clearing pass over all MAX_WINDOW slots, busy high meanwhile
// results cannot be stalled: each o_valid cycle is one transaction
module streaming_top_q_selector_unit #(
    parameter int MAX_WINDOW = 128,
    parameter int MAX_KEEP   = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  stqs_pkg::t_in   i_in,
    output logic            o_valid,
    output stqs_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data
);
    stqs_pkg::t_cmd cmd;
    stqs_pkg::t_sts sts;

    stqs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_func (i_in.func),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    stqs_dp #(
        .MAX_WINDOW(MAX_WINDOW),
        .MAX_KEEP  (MAX_KEEP)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in      (i_in),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_sts     (sts),
        .o_out     (o_out)
    );

    assign o_valid = cmd.em_out;

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a busy period");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |=> !busy) else $error("busy after last result");
    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.func == stqs_pkg::FUNC_CLEAR) |=> !busy)
        else $error("clear did not finish in one cycle");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("no clearing pass after reset");
`endif
endmodule

FILE: design/stqs_ram.sv
// generic single write port ram with registered read
module stqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/stqs_ctrl.sv
// controller state machine for the streaming top-q selector
module stqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_func,
    input  stqs_pkg::t_sts i_sts,
    output stqs_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_P0   = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_SWA  = 4'd4;
    localparam logic [3:0] S_SWB  = 4'd5;
    localparam logic [3:0] S_SWC  = 4'd6;
    localparam logic [3:0] S_SWD  = 4'd7;
    localparam logic [3:0] S_P2   = 4'd8;
    localparam logic [3:0] S_P3   = 4'd9;
    localparam logic [3:0] S_P4   = 4'd10;
    localparam logic [3:0] S_P6   = 4'd11;
    localparam logic [3:0] S_ERD  = 4'd12;
    localparam logic [3:0] S_EOUT = 4'd13;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;
    logic       r_query, n_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
            r_query <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_query <= n_query;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_query = r_query;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.acc = 1'b1;
                    if (i_func == stqs_pkg::FUNC_QUERY) begin
                        o_cmd.sel_init = 1'b1;
                        n_query        = 1'b1;
                        n_state        = S_P0;
                    end else if (i_func == stqs_pkg::FUNC_INSERT && i_sts.ins_sel) begin
                        o_cmd.sel_init = 1'b1;
                        n_query        = 1'b0;
                        n_state        = S_P0;
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_P0: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_P1;
            end
            S_P1: begin
                // pivot latched, then swap lo and hi
                o_cmd.ld_pv = 1'b1;
                n_ret       = S_P2;
                n_state     = S_SWA;
            end
            S_SWA: begin
                o_cmd.sw_ra = 1'b1;
                n_state     = S_SWB;
            end
            S_SWB: begin
                o_cmd.sw_rb = 1'b1;
                n_state     = S_SWC;
            end
            S_SWC: begin
                o_cmd.sw_wa = 1'b1;
                n_state     = S_SWD;
            end
            S_SWD: begin
                o_cmd.sw_wb = 1'b1;
                n_state     = r_ret;
            end
            S_P2: begin
                o_cmd.np_init = 1'b1;
                n_state       = S_P3;
            end
            S_P3: begin
                if (i_sts.i_gt_lo) begin
                    o_cmd.rd_im1 = 1'b1;
                    n_state      = S_P4;
                end else begin
                    o_cmd.sw_hinp = 1'b1;
                    n_ret         = S_P6;
                    n_state       = S_SWA;
                end
            end
            S_P4: begin
                o_cmd.step = 1'b1;
                if (i_sts.x_gt_pv) begin
                    n_ret   = S_P3;
                    n_state = S_SWA;
                end else begin
                    n_state = S_P3;
                end
            end
            S_P6: begin
                o_cmd.part_end = 1'b1;
                if (!i_sts.p_eq_t) begin
                    n_state = S_P0;
                end else if (r_query) begin
                    n_state = S_ERD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERD: begin
                o_cmd.em_rd = 1'b1;
                n_state     = S_EOUT;
            end
            S_EOUT: begin
                o_cmd.em_out = 1'b1;
                n_state      = i_sts.em_last ? S_IDLE : S_ERD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: design/stqs_dp.sv
// datapath: store, registers, pointers and compares of the selector
module stqs_dp #(
    parameter int MAX_WINDOW = 128,
    parameter int MAX_KEEP   = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stqs_pkg::t_cmd i_cmd,
    input  stqs_pkg::t_in  i_in,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    output stqs_pkg::t_sts o_sts,
    output stqs_pkg::t_out o_out
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int PW = $clog2(MAX_WINDOW + 1);

    logic [6:0]         r_keep;
    logic [7:0]         r_window;
    logic signed [31:0] r_thr;
    logic [PW-1:0]      r_fill;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_lo, r_hi, r_i, r_np, r_tgt, r_sa, r_sb;
    logic signed [31:0] r_pv, r_va;
    logic [6:0]         r_k;

    logic [15:0]   kq, kw;
    logic [PW-1:0] eff_w;
    logic [AW-1:0] tgt;
    logic [PW-1:0] pos;
    logic [AW-1:0] new_fill;
    logic          admit;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    // effective keep count and window
    always_comb begin
        kq = (r_keep == 7'd0) ? 16'd1 : {9'd0, r_keep};
        if (kq > 16'(MAX_KEEP)) kq = 16'(MAX_KEEP);
        if (kq > 16'(MAX_WINDOW - 1)) kq = 16'(MAX_WINDOW - 1);
        kw = (r_window < 8'd2) ? 16'd2 : {8'd0, r_window};
        if (kw > 16'(MAX_WINDOW)) kw = 16'(MAX_WINDOW);
        if (kw <= kq) kw = kq + 16'd1;
    end

    assign eff_w    = PW'(kw);
    assign tgt      = AW'(kw - kq);
    assign admit    = !(i_in.value < r_thr);
    assign pos      = (r_fill == '0 || r_fill > eff_w) ? eff_w : r_fill;
    assign new_fill = AW'(pos - PW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= stqs_pkg::KEEP_RESET;
            r_window <= stqs_pkg::WINDOW_RESET;
            r_thr    <= stqs_pkg::THR_RESET;
            r_fill   <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == stqs_pkg::CFG_KEEP) r_keep <= i_cfg_data[6:0];
                else r_window <= i_cfg_data;
            end
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.acc && i_in.func == stqs_pkg::FUNC_CLEAR) begin
                r_thr  <= stqs_pkg::THR_RESET;
                r_fill <= '0;
            end
            if (i_cmd.acc && i_in.func == stqs_pkg::FUNC_INSERT && admit) begin
                r_fill <= PW'(new_fill);
            end
            if (i_cmd.part_end && r_np == r_tgt) begin
                r_thr  <= r_pv;
                r_fill <= PW'(r_tgt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_init) begin
            r_lo  <= '0;
            r_hi  <= AW'(kw - 16'd1);
            r_tgt <= tgt;
        end
        if (i_cmd.ld_pv) begin
            r_pv <= ram_rdata;
            r_sa <= r_lo;
            r_sb <= r_hi;
        end
        if (i_cmd.sw_rb) r_va <= ram_rdata;
        if (i_cmd.np_init) begin
            r_np <= r_hi;
            r_i  <= r_hi;
        end
        if (i_cmd.step) begin
            r_i <= r_i - AW'(1);
            if (o_sts.x_gt_pv) begin
                r_np <= r_np - AW'(1);
                r_sa <= r_i - AW'(1);
                r_sb <= r_np - AW'(1);
            end
        end
        if (i_cmd.sw_hinp) begin
            r_sa <= r_hi;
            r_sb <= r_np;
        end
        if (i_cmd.part_end) begin
            if (r_np == r_tgt) r_k <= '0;
            else if (r_np > r_tgt) r_hi <= r_np - AW'(1);
            else r_lo <= r_np + AW'(1);
        end
        if (i_cmd.em_out) r_k <= r_k + 7'd1;
    end

    // write port: clearing pass, insert, then the two halves of a swap
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = r_sb;
        ram_wdata = r_va;
        priority if (i_cmd.clr_wr) begin
            ram_waddr = r_clr;
            ram_wdata = stqs_pkg::VALUE_MIN;
        end else if (i_cmd.acc && i_in.func == stqs_pkg::FUNC_INSERT && admit) begin
            ram_waddr = new_fill;
            ram_wdata = i_in.value;
        end else if (i_cmd.sw_wa) begin
            ram_waddr = r_sa;
            ram_wdata = ram_rdata;
        end else if (i_cmd.sw_wb) begin
            ram_waddr = r_sb;
        end else begin
            ram_we = 1'b0;
        end
    end

    always_comb begin
        priority if (i_cmd.rd_lo) ram_raddr = r_lo;
        else if (i_cmd.rd_im1) ram_raddr = r_i - AW'(1);
        else if (i_cmd.sw_ra) ram_raddr = r_sa;
        else if (i_cmd.sw_rb) ram_raddr = r_sb;
        else if (i_cmd.em_rd) ram_raddr = AW'(r_tgt + AW'(r_k));
        else ram_raddr = r_lo;
    end

    stqs_ram #(
        .WIDTH(32),
        .DEPTH(MAX_WINDOW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_sts.ins_sel  = admit && (new_fill == '0);
    assign o_sts.i_gt_lo  = (r_i > r_lo);
    assign o_sts.x_gt_pv  = ($signed(ram_rdata) > r_pv);
    assign o_sts.p_eq_t   = (r_np == r_tgt);
    assign o_sts.clr_last = (r_clr == AW'(MAX_WINDOW - 1));
    assign o_sts.em_last  = ((16'(r_k) + 16'd1) == kq);

    assign o_out.top_value = ram_rdata;
    assign o_out.threshold = r_thr;
    assign o_out.last      = o_sts.em_last;
endmodule

FILE: tb/streaming_top_q_selector_unit_test.sv
// self-checking testbench for the streaming top-q selector
`timescale 1ns / 1ps

module streaming_top_q_selector_unit_test;

    localparam int MAX_WINDOW = 128;
    localparam int MAX_KEEP   = 64;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    stqs_pkg::t_in  i_in;
    logic           o_valid;
    stqs_pkg::t_out o_out;
    logic           i_cfg_we;
    logic           i_cfg_idx;
    logic [7:0]     i_cfg_data;

    streaming_top_q_selector_unit #(
        .MAX_WINDOW(MAX_WINDOW),
        .MAX_KEEP  (MAX_KEEP)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in      (i_in),
        .o_valid   (o_valid),
        .o_out     (o_out),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    int             slot_vals [MAX_WINDOW];
    int             admit_thr;
    int unsigned    fill_pos;
    int unsigned    keep_reg;
    int unsigned    window_reg;
    stqs_pkg::t_out pending_tops[$];

    int errors;
    int items_sent;
    int tops_checked;
    int queries_sent;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1s;
        $display("Verification failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned keep_eff();
        int unsigned q;
        q = keep_reg;
        if (q < 1) q = 1;
        if (q > MAX_KEEP) q = MAX_KEEP;
        if (q > MAX_WINDOW - 1) q = MAX_WINDOW - 1;
        return q;
    endfunction

    function automatic int unsigned window_eff();
        int unsigned w;
        w = window_reg;
        if (w < 2) w = 2;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        if (w <= keep_eff()) w = keep_eff() + 1;
        return w;
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        int t;
        t = slot_vals[a];
        slot_vals[a] = slot_vals[b];
        slot_vals[b] = t;
    endfunction

    // larger values to the right of the pivot
    function automatic int unsigned split_range(input int unsigned lo, input int unsigned hi);
        int          pv;
        int unsigned np;
        int unsigned i;
        pv = slot_vals[lo];
        np = hi;
        swap_slots(lo, hi);
        for (i = hi; i > lo; i--) begin
            if (slot_vals[i-1] > pv) begin
                np--;
                swap_slots(i - 1, np);
            end
        end
        swap_slots(hi, np);
        return np;
    endfunction

    function automatic void select_top();
        int unsigned w, tgt, lo, hi, p;
        int          found;
        w = window_eff();
        tgt = w - keep_eff();
        lo = 0;
        hi = w - 1;
        found = slot_vals[tgt];
        while (lo <= hi) begin
            p = split_range(lo, hi);
            if (p == tgt) begin
                found = slot_vals[p];
                break;
            end else if (p > tgt) begin
                if (p == 0) break;
                hi = p - 1;
            end else begin
                lo = p + 1;
            end
        end
        admit_thr = found;
        fill_pos = tgt;
    endfunction

    function automatic void predict(input stqs_pkg::t_in it);
        int unsigned    w, q, k;
        stqs_pkg::t_out r;
        case (it.func)
            stqs_pkg::FUNC_INSERT: begin
                w = window_eff();
                if (it.value >= admit_thr) begin
                    if (fill_pos == 0 || fill_pos > w) fill_pos = w;
                    fill_pos--;
                    slot_vals[fill_pos] = it.value;
                    if (fill_pos == 0) select_top();
                end
            end
            stqs_pkg::FUNC_QUERY: begin
                select_top();
                w = window_eff();
                q = keep_eff();
                for (k = 0; k < q; k++) begin
                    r.top_value = slot_vals[w - q + k];
                    r.threshold = admit_thr;
                    r.last      = (k + 1 == q);
                    pending_tops.push_back(r);
                end
            end
            stqs_pkg::FUNC_CLEAR: begin
                admit_thr = -1;
                fill_pos = window_eff();
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(negedge i_clk) begin
        stqs_pkg::t_out e;
        if (i_rst_n && o_valid) begin
            if (pending_tops.size() == 0) begin
                report($sformatf("unexpected result %p", o_out));
            end else begin
                e = pending_tops.pop_front();
                tops_checked++;
                if (o_out.top_value !== e.top_value)
                    report($sformatf("top_value %0d, want %0d", o_out.top_value, e.top_value));
                if (o_out.threshold !== e.threshold)
                    report($sformatf("threshold %0d, want %0d", o_out.threshold, e.threshold));
                if (o_out.last !== e.last)
                    report($sformatf("last %0b, want %0b", o_out.last, e.last));
            end
        end
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(input logic [1:0] f, input logic [31:0] v, input int gap);
        stqs_pkg::t_in it;
        it.func  = f;
        it.value = v;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= it;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict(it);
        items_sent++;
        if (f == stqs_pkg::FUNC_QUERY) queries_sent++;
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
        while (pending_tops.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == stqs_pkg::CFG_KEEP) keep_reg = data & 8'h7F;
        else window_reg = data;
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        send_item(stqs_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'h8000_0000, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'h0000_0000, 1);
        send_item(stqs_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'hAAAA_5555, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'h5555_AAAA, 2);
        // query before the window has filled
        send_item(stqs_pkg::FUNC_QUERY, 32'h1234_5678, 0);
        // low values inserted after the query, at or above its new threshold
        send_item(stqs_pkg::FUNC_INSERT, 32'hFFFF_FFFE, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'h8000_0000, 0);
        // unused code is ignored
        send_item(stqs_pkg::FUNC_NONE, 32'hFFFF_FFFF, 0);
        send_item(stqs_pkg::FUNC_CLEAR, 32'h0, 0);
        send_item(stqs_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 0);
        send_item(stqs_pkg::FUNC_QUERY, 32'h0, 0);
        go_idle();
    endtask

    task automatic test_fill_small_window();
        // q=1 window=2: once the window has filled, each admitted insert triggers a selection
        write_reg(stqs_pkg::CFG_KEEP, 8'd1);
        write_reg(stqs_pkg::CFG_WINDOW, 8'd2);
        for (int i = 0; i < 6; i++) send_item(stqs_pkg::FUNC_INSERT, 32'd10 * i - 20, 0);
        send_item(stqs_pkg::FUNC_QUERY, 32'h0, 0);
        go_idle();
    endtask

    task automatic run_phase(input logic [7:0] keep, input logic [7:0] win, input int n);
        int r;
        write_reg(stqs_pkg::CFG_KEEP, keep);
        write_reg(stqs_pkg::CFG_WINDOW, win);
        // stale fill position after a window change is exercised by starting with inserts
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 85) send_item(stqs_pkg::FUNC_INSERT, rand_value(), rand_gap());
            else if (r < 93) send_item(stqs_pkg::FUNC_QUERY, $urandom, rand_gap());
            else if (r < 97) send_item(stqs_pkg::FUNC_CLEAR, $urandom, rand_gap());
            else send_item(stqs_pkg::FUNC_NONE, $urandom, rand_gap());
        end
        send_item(stqs_pkg::FUNC_QUERY, $urandom, 0);
        go_idle();
    endtask

    task automatic test_random_configs();
        run_phase(8'd16, 8'd32, 50);
        run_phase(8'd0, 8'd0, 40);      // both clamp to their minimum
        run_phase(8'd64, 8'd128, 50);
        run_phase(8'd255, 8'd255, 30);  // keep masked to 127, both clamped
        run_phase(8'd5, 8'd3, 50);      // window raised above keep
        run_phase(8'd3, 8'd40, 60);
        run_phase(8'd1, 8'd1, 30);
    endtask

    task automatic test_drain_pause();
        write_reg(stqs_pkg::CFG_KEEP, 8'd4);
        write_reg(stqs_pkg::CFG_WINDOW, 8'd9);
        for (int i = 0; i < 20; i++) begin
            send_item($urandom_range(0, 4) == 0 ? stqs_pkg::FUNC_QUERY : stqs_pkg::FUNC_INSERT,
                      rand_value(), 0);
            if (i == 10) begin
                // hold the next transaction until every result is out
                start <= 1'b0;
                @(negedge i_clk);
                while (pending_tops.size() != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
        end
        go_idle();
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        tops_checked = 0;
        queries_sent = 0;
        keep_reg = stqs_pkg::KEEP_RESET;
        window_reg = stqs_pkg::WINDOW_RESET;
        for (int i = 0; i < MAX_WINDOW; i++) slot_vals[i] = stqs_pkg::VALUE_MIN;
        admit_thr = -1;
        fill_pos = window_eff();
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= 1'b0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_fill_small_window();
        test_random_configs();
        test_drain_pause();

        go_idle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d transactions (%0d queries) over 9 register settings",
                 items_sent, queries_sent);
        $display("%0d results compared, %0d mismatches", tops_checked, errors);
        if (errors == 0 && pending_tops.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
